// File: design/usb_serial_console_port_macros.svh
// Assertion helpers for the serial console port
`ifndef USB_SERIAL_CONSOLE_PORT_MACROS_SVH
`define USB_SERIAL_CONSOLE_PORT_MACROS_SVH

// Checked outside reset only
`define USC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included
`define USC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: design/usc_pkg.sv
package usc_pkg;

  // Buffer sizes
  localparam int unsigned TX_DEPTH = 64;
  localparam int unsigned RX_DEPTH = 64;

  localparam int unsigned TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int unsigned TX_CW = $clog2(TX_DEPTH + 1);
  localparam int unsigned RX_AW = $clog2(RX_DEPTH);
  localparam int unsigned RX_CW = $clog2(RX_DEPTH + 1);

  // Interrupt pending bits
  localparam int unsigned PEND_TX_DONE  = 0;
  localparam int unsigned PEND_RX_AVAIL = 1;

  // Endpoint conf read bits
  localparam int unsigned CONF_TX_SPACE   = 1;
  localparam int unsigned CONF_RX_NONEMPT = 2;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_HOST  = 2'd2,
    KIND_NOP   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    REG_DATA       = 3'd0,
    REG_CONF       = 3'd1,
    REG_INT_RAW    = 3'd2,
    REG_INT_STATUS = 3'd3,
    REG_INT_ENABLE = 3'd4,
    REG_INT_CLEAR  = 3'd5
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_FLUSH = 2'b10
  } state_e;

  // Transmit buffer commands
  typedef struct packed {
    logic       wr;     // store wbyte at fill position (position 0 with clr)
    logic       clr;    // empty the buffer
    logic       start;  // restart readout at entry 0
    logic       step;   // advance readout by one entry
    logic [7:0] wbyte;
  } tx_ctl_t;

  // Receive FIFO commands
  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] wbyte;
  } rx_ctl_t;

  // One result
  typedef struct packed {
    logic [31:0] read_data;
    logic        irq;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic        rx_accepted;
  } result_t;

endpackage

// File: design/usc_tx_buf.sv
module usc_tx_buf (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  usc_pkg::tx_ctl_t          ctl_i,
  output logic [usc_pkg::TX_CW-1:0] count_o,
  output logic [7:0]                rbyte_o,
  output logic                      last_o
);

  logic [7:0]                mem_q [usc_pkg::TX_DEPTH];
  logic [usc_pkg::TX_CW-1:0] count_q, count_d;
  logic [usc_pkg::TX_AW-1:0] idx_q, idx_d;
  logic [usc_pkg::TX_AW-1:0] waddr;
  logic [7:0]                rbyte_q;

  // Readout index; the read port follows its next value so rbyte_q = mem[idx_q]
  always_comb begin
    idx_d = idx_q;
    if (ctl_i.start) begin
      idx_d = '0;
    end else if (ctl_i.step) begin
      idx_d = idx_q + 1'b1;
    end
  end

  // Fill position and count
  always_comb begin
    waddr = ctl_i.clr ? '0 : count_q[usc_pkg::TX_AW-1:0];
    if (ctl_i.clr) begin
      count_d = ctl_i.wr ? usc_pkg::TX_CW'(1) : '0;
    end else begin
      count_d = count_q + usc_pkg::TX_CW'(ctl_i.wr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  // Buffer memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem_q[waddr] <= ctl_i.wbyte;
    end
    rbyte_q <= mem_q[idx_d];
  end

  assign count_o = count_q;
  assign rbyte_o = rbyte_q;
  assign last_o  = ((usc_pkg::TX_CW'(idx_q) + usc_pkg::TX_CW'(1)) == count_q);

endmodule

// File: design/usc_rx_fifo.sv
module usc_rx_fifo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  usc_pkg::rx_ctl_t          ctl_i,
  output logic [usc_pkg::RX_CW-1:0] count_o,
  output logic [7:0]                rdata_o
);

  logic [7:0]                mem_q [usc_pkg::RX_DEPTH];
  logic [usc_pkg::RX_AW-1:0] head_q, head_d;
  logic [usc_pkg::RX_AW-1:0] tail_q, tail_d;
  logic [usc_pkg::RX_CW-1:0] count_q, count_d;
  logic [7:0]                rdata_q;

  // Pointer update with wrap at the depth
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (ctl_i.pop) begin
      head_d  = (head_q == usc_pkg::RX_AW'(usc_pkg::RX_DEPTH - 1)) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
    end
    if (ctl_i.push) begin
      tail_d  = (tail_q == usc_pkg::RX_AW'(usc_pkg::RX_DEPTH - 1)) ? '0 : tail_q + 1'b1;
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Storage; read port tracks the next head, new data forwarded on a same-entry write
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem_q[tail_q] <= ctl_i.wbyte;
    end
    if (ctl_i.push && (tail_q == head_d)) begin
      rdata_q <= ctl_i.wbyte;
    end else begin
      rdata_q <= mem_q[head_d];
    end
  end

  assign count_o = count_q;
  assign rdata_o = rdata_q;

endmodule

// File: design/usb_serial_console_port.sv
// Serial console port. Each input transfer is a bus read, a bus write or a byte
// from the host; it yields one result, except a flush with a host attached, which
// yields one result per buffered byte (tx_last on the final one). Ordinary items
// are taken at one per cycle while the result register drains. A flush holds the
// input while it starts the transmit buffer read, then sends one byte per cycle
// from its single read port while the output is not stalled. The TX buffer and RX
// FIFO contents are not cleared by reset, so the block is ready right after reset.
// host_connected sits at APB address 0.
`include "usb_serial_console_port_macros.svh"

module usb_serial_console_port (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // reg_sel[2:0], write_data[34:3], rx_byte[42:35]
  input  logic [1:0]  s_axis_tuser_i,   // kind[1:0]
  // Result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // read_data[31:0], irq[32], tx_byte[40:33],
                                        // rx_accepted[41]
  output logic [0:0]  m_axis_tuser_o,   // tx_valid[0]
  output logic        m_axis_tlast_o,   // tx_last
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  usc_pkg::state_e           state_q, state_d;
  usc_pkg::result_t          out_q, out_d;
  logic                      out_valid_q;
  logic                      out_free;
  logic                      load;
  logic                      in_acc;
  logic                      host_q;
  logic [1:0]                pend_q, pend_d;
  logic [31:0]               en_q, en_d;
  logic                      st_pend_q, st_pend_d;
  logic [7:0]                st_byte_q, st_byte_d;
  logic                      flush_go;
  logic [31:0]               rd;
  logic                      rx_acc;
  logic                      irq_now;

  usc_pkg::kind_e            kind;
  usc_pkg::reg_e             sel;
  logic [31:0]               wdata;
  logic [7:0]                hbyte;

  usc_pkg::tx_ctl_t          tx_ctl;
  usc_pkg::rx_ctl_t          rx_ctl;
  logic [usc_pkg::TX_CW-1:0] tx_count;
  logic [7:0]                tx_rbyte;
  logic                      tx_last;
  logic [usc_pkg::RX_CW-1:0] rx_count;
  logic [7:0]                rx_rdata;

  // Field unpacking
  assign kind  = usc_pkg::kind_e'(s_axis_tuser_i);
  assign sel   = usc_pkg::reg_e'(s_axis_tdata_i[2:0]);
  assign wdata = s_axis_tdata_i[34:3];
  assign hbyte = s_axis_tdata_i[42:35];

  // Handshakes
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == usc_pkg::ST_IDLE) && out_free;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {31'd0, host_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      host_q <= 1'b0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      host_q <= pwdata[0];
    end
  end

  // Item decode, register updates and flush sequencing
  always_comb begin
    state_d      = state_q;
    out_d        = out_q;
    load         = 1'b0;
    pend_d       = pend_q;
    en_d         = en_q;
    st_pend_d    = st_pend_q;
    st_byte_d    = st_byte_q;
    flush_go     = 1'b0;
    rd           = '0;
    rx_acc       = 1'b0;
    tx_ctl       = '0;
    tx_ctl.wbyte = wdata[7:0];
    rx_ctl       = '0;
    rx_ctl.wbyte = hbyte;
    irq_now      = 1'b0;

    case (state_q)
      usc_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (kind)
            usc_pkg::KIND_READ: begin
              case (sel)
                usc_pkg::REG_DATA: begin
                  if (rx_count != '0) begin
                    rd         = {24'd0, rx_rdata};
                    rx_ctl.pop = 1'b1;
                    if (rx_count == usc_pkg::RX_CW'(1)) begin
                      pend_d[usc_pkg::PEND_RX_AVAIL] = 1'b0;
                    end
                  end
                end
                usc_pkg::REG_CONF: begin
                  rd[usc_pkg::CONF_TX_SPACE]   = (tx_count < usc_pkg::TX_CW'(usc_pkg::TX_DEPTH));
                  rd[usc_pkg::CONF_RX_NONEMPT] = (rx_count != '0);
                end
                usc_pkg::REG_INT_RAW:    rd = {30'd0, pend_q};
                usc_pkg::REG_INT_STATUS: rd = {30'd0, pend_q & en_q[1:0]};
                usc_pkg::REG_INT_ENABLE: rd = en_q;
                default:                 rd = '0;
              endcase
            end
            usc_pkg::KIND_WRITE: begin
              case (sel)
                usc_pkg::REG_DATA: begin
                  tx_ctl.wr = 1'b1;
                  // Full buffer: flush first (with no host, just empty it), then store at entry 0
                  if (tx_count == usc_pkg::TX_CW'(usc_pkg::TX_DEPTH)) begin
                    pend_d[usc_pkg::PEND_TX_DONE] = 1'b1;
                    if (host_q) begin
                      flush_go  = 1'b1;
                      tx_ctl.wr = 1'b0;
                      st_pend_d = 1'b1;
                      st_byte_d = wdata[7:0];
                    end else begin
                      tx_ctl.clr = 1'b1;
                    end
                  end
                end
                usc_pkg::REG_CONF: begin
                  if (wdata[0] && (tx_count != '0)) begin
                    pend_d[usc_pkg::PEND_TX_DONE] = 1'b1;
                    if (host_q) begin
                      flush_go  = 1'b1;
                      st_pend_d = 1'b0;
                    end else begin
                      tx_ctl.clr = 1'b1;
                    end
                  end
                end
                usc_pkg::REG_INT_ENABLE: en_d   = wdata;
                usc_pkg::REG_INT_CLEAR:  pend_d = pend_q & ~wdata[1:0];
                default: ;
              endcase
            end
            usc_pkg::KIND_HOST: begin
              if (rx_count < usc_pkg::RX_CW'(usc_pkg::RX_DEPTH)) begin
                rx_ctl.push = 1'b1;
                rx_acc      = 1'b1;
                if (rx_count == '0) begin
                  pend_d[usc_pkg::PEND_RX_AVAIL] = 1'b1;
                end
              end
            end
            default: ;
          endcase

          irq_now = |(pend_d & en_d[1:0]);
          if (flush_go) begin
            state_d      = usc_pkg::ST_FLUSH;
            tx_ctl.start = 1'b1;
          end else begin
            load              = 1'b1;
            out_d.read_data   = rd;
            out_d.irq         = irq_now;
            out_d.tx_valid    = 1'b0;
            out_d.tx_byte     = '0;
            out_d.tx_last     = 1'b1;
            out_d.rx_accepted = rx_acc;
          end
        end
      end
      usc_pkg::ST_FLUSH: begin
        // One buffered byte per free output slot
        if (out_free) begin
          load              = 1'b1;
          out_d.read_data   = '0;
          out_d.irq         = |(pend_q & en_q[1:0]);
          out_d.tx_valid    = 1'b1;
          out_d.tx_byte     = tx_rbyte;
          out_d.tx_last     = tx_last;
          out_d.rx_accepted = 1'b0;
          tx_ctl.step       = 1'b1;
          if (tx_last) begin
            tx_ctl.clr   = 1'b1;
            tx_ctl.wr    = st_pend_q;
            tx_ctl.wbyte = st_byte_q;
            state_d      = usc_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = usc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= usc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      pend_q      <= '0;
      en_q        <= '0;
      st_pend_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= load || (out_valid_q && !m_axis_tready_i);
      pend_q      <= pend_d;
      en_q        <= en_d;
      st_pend_q   <= st_pend_d;
    end
  end

  // Result and deferred-byte payload
  always_ff @(posedge clk_i) begin
    out_q     <= out_d;
    st_byte_q <= st_byte_d;
  end

  usc_tx_buf u_tx_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (tx_ctl),
    .count_o (tx_count),
    .rbyte_o (tx_rbyte),
    .last_o  (tx_last)
  );

  usc_rx_fifo u_rx_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (rx_ctl),
    .count_o (rx_count),
    .rdata_o (rx_rdata)
  );

  // Output packing
  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = {6'd0, out_q.rx_accepted, out_q.tx_byte, out_q.irq,
                              out_q.read_data};
  assign m_axis_tuser_o[0] = out_q.tx_valid;
  assign m_axis_tlast_o    = out_q.tx_last;

  // Checks
  `USC_ASSERT(a_no_accept_in_flush, (state_q == usc_pkg::ST_FLUSH) |-> !s_axis_tready_o, "input taken during flush")
  `USC_ASSERT(a_tx_count_range, tx_count <= usc_pkg::TX_CW'(usc_pkg::TX_DEPTH), "tx count beyond depth")
  `USC_ASSERT(a_rx_avail_empty, (rx_count == '0) |-> !pend_q[usc_pkg::PEND_RX_AVAIL], "rx available with empty fifo")
  `USC_ASSERT(a_flush_nonempty, (state_q == usc_pkg::ST_FLUSH) |-> (tx_count != '0), "flush of empty buffer")

endmodule
